FILE: rtl/core/evfm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// evfm_pkg
// Shared types, codes and constants of the encoder velocity fault monitor.
// ----------------------------------------------------------------------------
package evfm_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;
  localparam int MAG_W      = 36;
  localparam int MUL_A_W    = 16;

  localparam logic [19:0] VEL_SCALE = 20'd1000000;
  localparam logic [15:0] SAT16     = 16'hFFFF;

  localparam logic [15:0] RST_ALPHA  = 16'd52429;
  localparam logic [19:0] RST_GLITCH = 20'd100000;
  localparam logic [19:0] RST_STALL  = 20'd50;
  localparam logic [14:0] RST_DRIVE  = 15'd3000;
  localparam logic [15:0] RST_DSAMP  = 16'd20;
  localparam logic [30:0] RST_LIMIT  = 31'd150000;

  typedef enum logic [1:0] {
    OP_SAMPLE  = 2'd0,
    OP_CLR_ONE = 2'd1,
    OP_CLR_ALL = 2'd2,
    OP_NONE    = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    H_OK     = 2'd0,
    H_DISC   = 2'd1,
    H_GLITCH = 2'd2,
    H_UNUSED = 2'd3
  } health_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ALPHA  = 3'd0,
    CFG_GLITCH = 3'd1,
    CFG_STALL  = 3'd2,
    CFG_DRIVE  = 3'd3,
    CFG_DSAMP  = 3'd4,
    CFG_LIMIT  = 3'd5,
    CFG_POL    = 3'd6,
    CFG_BIAS   = 3'd7
  } cfg_reg_e;

  typedef struct packed {
    logic [1:0]         opcode;
    logic [1:0]         channel;
    logic [15:0]        counter_value;
    logic [15:0]        period_us;
    logic signed [15:0] motor_drive;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         out_channel;
    logic signed [31:0] position;
    logic signed [31:0] velocity;
    logic [1:0]         health;
    logic [3:0]         fault_mask;
    logic [15:0]        glitch_total;
    logic [15:0]        disconnect_total;
  } out_item_t;

  function automatic logic [15:0] inc_sat(input logic [15:0] x);
    return (x != SAT16) ? x + 16'd1 : x;
  endfunction

endpackage

FILE: rtl/core/evfm_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// evfm_in_if
// Input item channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface evfm_in_if;
  logic               valid;
  logic               ready;
  evfm_pkg::in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/core/evfm_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// evfm_out_if
// Result item channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface evfm_out_if;
  logic                valid;
  logic                ready;
  evfm_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/core/evfm_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// evfm_div
// Bit-serial restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module evfm_div #(
  parameter int NUM_W = 44
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [15:0]      den_i,
  output logic             done_o,
  output logic [NUM_W-1:0] quo_o
);
  localparam int CNT_W = $clog2(NUM_W + 1);

  logic             busy_q, done_q;
  logic [CNT_W-1:0] cnt_q;
  logic [15:0]      rem_q, den_q;
  logic [NUM_W-1:0] num_q;
  logic [16:0]      rem_sh;
  logic             ge;
  logic [16:0]      rem_sub;

  assign rem_sh  = {rem_q, num_q[NUM_W-1]};
  assign ge      = rem_sh >= {1'b0, den_q};
  assign rem_sub = ge ? rem_sh - {1'b0, den_q} : rem_sh;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(NUM_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= num_i;
      den_q <= den_i;
      rem_q <= '0;
    end else if (busy_q) begin
      num_q <= {num_q[NUM_W-2:0], ge};
      rem_q <= rem_sub[15:0];
    end
  end

  assign done_o = done_q;
  assign quo_o  = num_q;
endmodule

FILE: rtl/core/evfm_mul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// evfm_mul
// Shift-add multiplier, one bit of the unsigned weight per cycle.
// ----------------------------------------------------------------------------
module evfm_mul #(
  parameter int D_W = 41
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start_i,
  input  logic [evfm_pkg::MUL_A_W-1:0]         a_i,
  input  logic signed [D_W-1:0]                b_i,
  output logic                                 done_o,
  output logic signed [D_W+evfm_pkg::MUL_A_W-1:0] prod_o
);
  import evfm_pkg::*;

  localparam int P_W   = D_W + MUL_A_W;
  localparam int CNT_W = $clog2(MUL_A_W + 1);

  logic               busy_q, done_q;
  logic [CNT_W-1:0]   cnt_q;
  logic [MUL_A_W-1:0] a_q;
  logic signed [P_W-1:0] m_q, acc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(MUL_A_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q   <= a_i;
      m_q   <= P_W'(b_i);
      acc_q <= '0;
    end else if (busy_q) begin
      a_q <= a_q >> 1;
      m_q <= m_q <<< 1;
      if (a_q[0]) begin
        acc_q <= acc_q + m_q;
      end
    end
  end

  assign done_o = done_q;
  assign prod_o = acc_q;
endmodule

FILE: rtl/core/encoder_velocity_fault_monitor.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// encoder_velocity_fault_monitor
// Per-channel encoder position, velocity, glitch and disconnect monitor.
// ----------------------------------------------------------------------------
// One item is in flight at a time. A sample item passes, in order, through
// the delta and scale product, the bit-serial divide by the period, the
// health check, the limit, the bit-serial filter multiply and the result
// load, and then goes back to idle before the next input transfer. Clear
// items, ignored samples and unknown opcodes go straight to the result load.
// The next item is taken while the previous result still waits for its
// transfer; a result only loads once the output register is free, so a held
// result stalls the following item.
// ----------------------------------------------------------------------------
module encoder_velocity_fault_monitor #(
  parameter int CHANNELS  = 4,
  parameter int FRAC_BITS = 8
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [evfm_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [evfm_pkg::CFG_DATA_W-1:0] cfg_data_i,
  evfm_in_if.sink                         in_i,
  evfm_out_if.source                      out_o
);
  import evfm_pkg::*;

  localparam int CH_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int NUM_W = MAG_W + FRAC_BITS;
  localparam int RAW_W = NUM_W + 2;
  localparam int FV_W  = 32 + FRAC_BITS;
  localparam int D_W   = FV_W + 1;
  localparam int P_W   = D_W + MUL_A_W;
  localparam int HALF  = (1 << FRAC_BITS) / 2;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_MAG  = 7'b0000010,
    S_DIV  = 7'b0000100,
    S_HLTH = 7'b0001000,
    S_LIM  = 7'b0010000,
    S_FILT = 7'b0100000,
    S_RES  = 7'b1000000
  } state_e;

  // configuration
  logic [15:0] alpha_q;
  logic [19:0] glitch_q, stall_q;
  logic [14:0] drive_q;
  logic [15:0] dsamp_q;
  logic [30:0] limit_q;
  logic [3:0]  pol_q;
  logic [63:0] bias_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alpha_q  <= RST_ALPHA;
      glitch_q <= RST_GLITCH;
      stall_q  <= RST_STALL;
      drive_q  <= RST_DRIVE;
      dsamp_q  <= RST_DSAMP;
      limit_q  <= RST_LIMIT;
      pol_q    <= '0;
      bias_q   <= '0;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        CFG_ALPHA:  alpha_q  <= cfg_data_i[15:0];
        CFG_GLITCH: glitch_q <= cfg_data_i[19:0];
        CFG_STALL:  stall_q  <= cfg_data_i[19:0];
        CFG_DRIVE:  drive_q  <= cfg_data_i[14:0];
        CFG_DSAMP:  dsamp_q  <= cfg_data_i[15:0];
        CFG_LIMIT:  limit_q  <= cfg_data_i[30:0];
        CFG_POL:    pol_q    <= cfg_data_i[3:0];
        CFG_BIAS:   bias_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // per-channel state
  logic [15:0]            last_q  [CHANNELS];
  logic [31:0]            pos_q   [CHANNELS];
  logic signed [FV_W-1:0] filt_q  [CHANNELS];
  health_e                health_q[CHANNELS];
  logic [15:0]            fc_q    [CHANNELS];
  logic [15:0]            sc_q    [CHANNELS];
  logic [15:0]            gc_q    [CHANNELS];
  logic [15:0]            dc_q    [CHANNELS];
  logic signed [FV_W-1:0] lgv_q   [CHANNELS];

  state_e                  state_q;
  in_item_t                item_q;
  logic                    neg_q;
  logic signed [RAW_W-1:0] raw_q, sel_q;
  logic signed [FV_W-1:0]  r_q;
  logic                    out_valid_q;
  out_item_t               out_q;

  logic [CH_W-1:0] cidx, in_cidx;
  logic            chan_ok, in_chan_ok, in_xfer, out_xfer, res_load;

  assign cidx       = CH_W'(item_q.channel);
  assign in_cidx    = CH_W'(in_i.data.channel);
  assign chan_ok    = int'(item_q.channel) < CHANNELS;
  assign in_chan_ok = int'(in_i.data.channel) < CHANNELS;
  assign in_i.ready = (state_q == S_IDLE);
  assign in_xfer    = in_i.valid && in_i.ready;
  assign out_xfer   = out_valid_q && out_o.ready;
  assign res_load   = (state_q == S_RES) && (!out_valid_q || out_o.ready);

  // delta and scaled magnitude
  logic [15:0]      delta;
  logic [15:0]      absd;
  logic [MAG_W-1:0] mag;
  logic [NUM_W-1:0] num;
  logic             div_start, div_done;
  logic [NUM_W-1:0] quo;

  assign delta     = item_q.counter_value - last_q[cidx];
  assign absd      = delta[15] ? 16'(-delta) : delta;
  assign mag       = MAG_W'(absd) * MAG_W'(VEL_SCALE);
  assign num       = (NUM_W'(mag) << FRAC_BITS) + NUM_W'(item_q.period_us >> 1);
  assign div_start = (state_q == S_MAG);

  evfm_div #(.NUM_W(NUM_W)) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .num_i  (num),
    .den_i  (item_q.period_us),
    .done_o (div_done),
    .quo_o  (quo)
  );

  logic signed [RAW_W-1:0] q_s, raw_d;
  logic signed [15:0]      bias16;

  assign bias16 = bias_q[{item_q.channel, 4'b0000} +: 16];
  assign q_s    = signed'(RAW_W'(quo));
  assign raw_d  = (neg_q ? -q_s : q_s) - (RAW_W'(bias16) <<< FRAC_BITS);

  // health check
  logic [RAW_W-1:0]        av, glim, slim;
  logic signed [16:0]      drv_s;
  logic [16:0]             drv_abs;
  health_e                 h_d;
  logic [15:0]             fc_d, sc_d, gc_d, dc_d;
  logic signed [FV_W-1:0]  lgv_d;
  logic signed [RAW_W-1:0] sel_d;

  assign av      = raw_q[RAW_W-1] ? RAW_W'(-raw_q) : RAW_W'(raw_q);
  assign glim    = RAW_W'(glitch_q) << FRAC_BITS;
  assign slim    = RAW_W'(stall_q) << FRAC_BITS;
  assign drv_s   = 17'(item_q.motor_drive);
  assign drv_abs = drv_s[16] ? 17'(-drv_s) : 17'(drv_s);

  always_comb begin
    h_d   = health_q[cidx];
    fc_d  = fc_q[cidx];
    sc_d  = sc_q[cidx];
    gc_d  = gc_q[cidx];
    dc_d  = dc_q[cidx];
    lgv_d = lgv_q[cidx];
    if (av > glim) begin
      h_d  = H_GLITCH;
      fc_d = inc_sat(fc_q[cidx]);
      gc_d = inc_sat(gc_q[cidx]);
    end else if (drv_abs > {2'b00, drive_q} && av < slim) begin
      sc_d = inc_sat(sc_q[cidx]);
      if (sc_d >= dsamp_q) begin
        if (health_q[cidx] != H_DISC) begin
          dc_d = inc_sat(dc_q[cidx]);
        end
        h_d  = H_DISC;
        fc_d = inc_sat(fc_q[cidx]);
      end
    end else begin
      if (health_q[cidx] != H_OK) begin
        if (fc_q[cidx] != 16'd0) begin
          fc_d = fc_q[cidx] - 16'd1;
        end
        if (fc_d == 16'd0 && av < glim) begin
          h_d  = H_OK;
          sc_d = '0;
        end
      end else begin
        sc_d = '0;
        fc_d = '0;
      end
      if (av < glim) begin
        lgv_d = FV_W'(raw_q);
      end
    end
    case (h_d)
      H_DISC:   sel_d = '0;
      H_GLITCH: sel_d = RAW_W'(lgv_d);
      default:  sel_d = raw_q;
    endcase
  end

  // limit and filter
  logic [RAW_W-1:0]       sel_abs, lim;
  logic signed [FV_W-1:0] r_d;
  logic signed [D_W-1:0]  fdiff;
  logic                   mul_start, mul_done;
  logic signed [P_W-1:0]  prod, prod_rnd;
  logic signed [FV_W-1:0] filt_new;

  assign sel_abs   = sel_q[RAW_W-1] ? RAW_W'(-sel_q) : RAW_W'(sel_q);
  assign lim       = RAW_W'(limit_q) << FRAC_BITS;
  assign r_d       = (sel_abs > lim) ? '0 : FV_W'(sel_q);
  assign fdiff     = D_W'(filt_q[cidx]) - D_W'(r_d);
  assign mul_start = (state_q == S_LIM);

  evfm_mul #(.D_W(D_W)) u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(mul_start),
    .a_i    (alpha_q),
    .b_i    (fdiff),
    .done_o (mul_done),
    .prod_o (prod)
  );

  assign prod_rnd = (prod + P_W'(32768)) >>> 16;
  assign filt_new = r_q + FV_W'(prod_rnd);

  // result
  logic [3:0]             fmask;
  logic signed [FV_W-1:0] vel_t;
  out_item_t              res;

  always_comb begin
    fmask = '0;
    for (int i = 0; i < CHANNELS && i < 4; i++) begin
      fmask[i] = (health_q[i] != H_OK);
    end
  end

  assign vel_t = filt_q[cidx] + FV_W'(HALF);

  always_comb begin
    res             = '0;
    res.out_channel = item_q.channel;
    res.fault_mask  = fmask;
    if (chan_ok) begin
      res.position         = pos_q[cidx];
      res.velocity         = 32'(vel_t >>> FRAC_BITS);
      res.health           = health_q[cidx];
      res.glitch_total     = gc_q[cidx];
      res.disconnect_total = dc_q[cidx];
    end
  end

  // control and state update
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      for (int i = 0; i < CHANNELS; i++) begin
        last_q[i]   <= '0;
        pos_q[i]    <= '0;
        filt_q[i]   <= '0;
        health_q[i] <= H_OK;
        fc_q[i]     <= '0;
        sc_q[i]     <= '0;
        gc_q[i]     <= '0;
        dc_q[i]     <= '0;
        lgv_q[i]    <= '0;
      end
    end else begin
      if (res_load) begin
        out_valid_q <= 1'b1;
      end else if (out_xfer) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_xfer) begin
            if (op_e'(in_i.data.opcode) == OP_SAMPLE && in_chan_ok &&
                in_i.data.period_us != 16'd0) begin
              state_q <= S_MAG;
            end else begin
              state_q <= S_RES;
            end
            if (op_e'(in_i.data.opcode) == OP_CLR_ONE && in_chan_ok) begin
              health_q[in_cidx] <= H_OK;
              fc_q[in_cidx]     <= '0;
              sc_q[in_cidx]     <= '0;
            end else if (op_e'(in_i.data.opcode) == OP_CLR_ONE ||
                         op_e'(in_i.data.opcode) == OP_CLR_ALL) begin
              for (int i = 0; i < CHANNELS; i++) begin
                health_q[i] <= H_OK;
                fc_q[i]     <= '0;
                sc_q[i]     <= '0;
              end
            end
          end
        end
        S_MAG: begin
          last_q[cidx] <= item_q.counter_value;
          pos_q[cidx]  <= pos_q[cidx] + {{16{delta[15]}}, delta};
          state_q      <= S_DIV;
        end
        S_DIV: begin
          if (div_done) begin
            state_q <= S_HLTH;
          end
        end
        S_HLTH: begin
          health_q[cidx] <= h_d;
          fc_q[cidx]     <= fc_d;
          sc_q[cidx]     <= sc_d;
          gc_q[cidx]     <= gc_d;
          dc_q[cidx]     <= dc_d;
          lgv_q[cidx]    <= lgv_d;
          state_q        <= S_LIM;
        end
        S_LIM: begin
          state_q <= S_FILT;
        end
        S_FILT: begin
          if (mul_done) begin
            filt_q[cidx] <= filt_new;
            state_q      <= S_RES;
          end
        end
        S_RES: begin
          if (res_load) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      item_q <= in_i.data;
    end
    if (state_q == S_MAG) begin
      neg_q <= delta[15] ^ pol_q[item_q.channel];
    end
    if (state_q == S_DIV && div_done) begin
      raw_q <= raw_d;
    end
    if (state_q == S_HLTH) begin
      sel_q <= sel_d;
    end
    if (state_q == S_LIM) begin
      r_q <= r_d;
    end
    if (res_load) begin
      out_q <= res;
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

  a_div_in_div : assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == S_DIV)
    else $error("divider finished outside the divide step");

  a_mul_in_filt : assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_done |-> state_q == S_FILT)
    else $error("multiplier finished outside the filter step");

  a_xfer_leaves_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> state_q != S_IDLE)
    else $error("input transfer did not start work");

  a_res_loads_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RES && (!out_valid_q || out_o.ready)) |=> out_valid_q)
    else $error("result not presented");
endmodule
